// File: rtl/core/cfsc_pkg.sv
// ----------------------------------------------------------------------------
// cfsc_pkg: shared types and constants for the frequency shift classifier
// Holds mode, verdict, register index and sequencer codes, threshold bundle
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package cfsc_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned InW   = 24;  // sample_count and thresholds
  localparam int unsigned SampW = 5;   // calibration sample counter
  localparam int unsigned DataW = 32;  // tdata width on both streams
  localparam int unsigned IdxW  = 2;   // configuration register index

  // Defaults for the top level parameters
  localparam int unsigned CalSamplesDef = 21;
  localparam int unsigned CountWidthDef = 24;

  // Threshold reset values
  localparam logic [InW-1:0] MetalThrRst    = 24'd3350;
  localparam logic [InW-1:0] RiseIntfThrRst = 24'd12000;
  localparam logic [InW-1:0] FallIntfThrRst = 24'd4000;

  typedef enum logic [1:0] {
    ModeWait = 2'd0,
    ModeCal  = 2'd1,
    ModeDet  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    VerdNone  = 2'd0,
    VerdMetal = 2'd1,
    VerdIntf  = 2'd2
  } verdict_e;

  typedef enum logic [IdxW-1:0] {
    CfgMetal    = 2'd0,
    CfgRiseIntf = 2'd1,
    CfgFallIntf = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SeqIdle = 2'd0,
    SeqDiv  = 2'd1,
    SeqCmp  = 2'd2,
    SeqFin  = 2'd3
  } seq_e;

  typedef struct packed {
    logic [InW-1:0] metal;
    logic [InW-1:0] rise_intf;
    logic [InW-1:0] fall_intf;
  } thr_t;

endpackage

`default_nettype wire

// File: rtl/core/calibrated_frequency_shift_classifier_top.sv
// ----------------------------------------------------------------------------
// calibrated_frequency_shift_classifier_top: metal detector classifier core
// Averages a calibration run of gate counts into a reference, then sorts
// each later count into searching, metal or interference by its shift.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       count, cal button, det button
//   m_axis    out  m_axis_tvalid/tready       mode, reference, verdict, lamps
//   cfg       in   cfg_valid/cfg_ready        register index, 24-bit value
//
// A calibrating item runs accept, one divider step per quotient bit (one
// bit per cycle), divider done and output load; a detecting item runs accept,
// compare and output load, a waiting item accept and output load.
// Reset leaves the block calibrating with a zero total and reference.
// A result that is not taken holds the sequencer in its final state; the
// input side reopens as soon as the result moves into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_frequency_shift_classifier_top #(
  parameter int unsigned CAL_SAMPLES = cfsc_pkg::CalSamplesDef,
  parameter int unsigned COUNT_WIDTH = cfsc_pkg::CountWidthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // tdata: [23:0] sample_count, [24] cal_pressed, [25] det_pressed
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire  [cfsc_pkg::DataW-1:0]   s_axis_tdata_i,
  // tdata: [1:0] mode_now, [25:2] reference_freq, [27:26] verdict,
  //        [28] green_on, [29] red_on, [30] buzzer_on
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [cfsc_pkg::DataW-1:0]   m_axis_tdata_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [cfsc_pkg::IdxW-1:0]    cfg_index_i,
  input  wire  [cfsc_pkg::InW-1:0]     cfg_data_i
);
  import cfsc_pkg::*;

  localparam int unsigned CntW = (COUNT_WIDTH < InW) ? COUNT_WIDTH : InW;
  localparam int unsigned TotW = CntW + SampW;

  thr_t             thr;
  logic             acc;
  logic [CntW-1:0]  cnt;
  logic             cal_btn;
  logic             det_btn;
  logic [TotW-1:0]  total_sum;
  logic [SampW-1:0] samp_inc;
  logic             div_start;
  logic             div_done;
  logic [CntW-1:0]  div_quo;
  logic             rise;
  logic [CntW-1:0]  mag;
  logic [InW-1:0]   mag_ext;

  seq_e             state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [SampW-1:0] samples_q, samples_d;
  logic [CntW-1:0]  ref_q, ref_d;
  logic [CntW:0]    sub_q, sub_d;
  verdict_e         verdict_q, verdict_d;
  logic             m_valid_q, m_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;

  cfsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thr_o       (thr)
  );

  cfsc_div #(
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_sum),
    .divisor_i  (samp_inc),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Unpack the input transfer
  assign s_axis_tready_o = (state_q == SeqIdle);
  assign acc       = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt       = s_axis_tdata_i[CntW-1:0];
  assign cal_btn   = s_axis_tdata_i[InW];
  assign det_btn   = s_axis_tdata_i[InW+1];
  assign total_sum = total_q + TotW'(cnt);
  assign samp_inc  = samples_q + 1'b1;

  // Shift direction and magnitude from the registered difference
  assign rise    = !sub_q[CntW] && (sub_q[CntW-1:0] != '0);
  assign mag     = sub_q[CntW] ? CntW'(~sub_q[CntW-1:0] + 1'b1) : sub_q[CntW-1:0];
  assign mag_ext = InW'(mag);

  // Sequencer: next state, mode update and result assembly
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    total_d    = total_q;
    samples_d  = samples_q;
    ref_d      = ref_q;
    sub_d      = sub_q;
    verdict_d  = verdict_q;
    m_valid_d  = m_valid_q;
    out_data_d = out_data_q;
    div_start  = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      SeqIdle: begin
        if (acc) begin
          verdict_d = VerdNone;
          unique case (mode_q)
            ModeCal: begin
              total_d   = total_sum;
              samples_d = samp_inc;
              if (samp_inc >= SampW'(CAL_SAMPLES)) begin
                mode_d = ModeWait;
              end
              if (samp_inc != '0) begin
                div_start = 1'b1;
                state_d   = SeqDiv;
              end else begin
                state_d = SeqFin;
              end
            end
            ModeDet: begin
              sub_d = {1'b0, cnt} - {1'b0, ref_q};
              if (cal_btn && det_btn) begin
                mode_d = ModeWait;
              end
              state_d = SeqCmp;
            end
            ModeWait: begin
              if (cal_btn && !det_btn) begin
                mode_d    = ModeCal;
                total_d   = '0;
                samples_d = '0;
              end else if (det_btn && !cal_btn) begin
                mode_d = ModeDet;
              end
              state_d = SeqFin;
            end
            default: state_d = SeqFin;
          endcase
        end
      end
      SeqDiv: begin
        if (div_done) begin
          ref_d   = div_quo;
          state_d = SeqFin;
        end
      end
      SeqCmp: begin
        // Interference wins over metal
        priority if (rise && (mag_ext > thr.rise_intf)) begin
          verdict_d = VerdIntf;
        end else if (rise && (mag_ext > thr.metal)) begin
          verdict_d = VerdMetal;
        end else if (!rise && (mag_ext > thr.fall_intf)) begin
          verdict_d = VerdIntf;
        end else begin
          verdict_d = VerdNone;
        end
        state_d = SeqFin;
      end
      SeqFin: begin
        // Load the output register once it is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          out_data_d = {1'b0,
                        (verdict_q == VerdMetal),
                        (verdict_q == VerdIntf),
                        (verdict_q != VerdNone),
                        verdict_q,
                        InW'(ref_q),
                        mode_q};
          state_d    = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SeqIdle;
      mode_q    <= ModeCal;
      total_q   <= '0;
      samples_q <= '0;
      ref_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      total_q   <= total_d;
      samples_q <= samples_d;
      ref_q     <= ref_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q      <= sub_d;
    verdict_q  <= verdict_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !s_axis_tready_o)
    else $error("input side open right after an accepted transfer");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == SeqDiv))
    else $error("divider finished outside the divide state");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == SeqFin))
    else $error("result loaded outside the final state");

  a_samples_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    samples_q <= SampW'(CAL_SAMPLES))
    else $error("calibration sample count ran past its limit");
`endif

endmodule

`default_nettype wire

// File: rtl/core/cfsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfsc_cfg_regs: threshold register bank
// Takes one register write per transfer on the configuration channel and
// presents the three thresholds as one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfsc_cfg_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [cfsc_pkg::IdxW-1:0]    cfg_index_i,
  input  wire  [cfsc_pkg::InW-1:0]     cfg_data_i,
  output cfsc_pkg::thr_t               thr_o
);
  import cfsc_pkg::*;

  thr_t thr_q, thr_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMetal:    thr_d.metal     = cfg_data_i;
        CfgRiseIntf: thr_d.rise_intf = cfg_data_i;
        CfgFallIntf: thr_d.fall_intf = cfg_data_i;
        default:     thr_d = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.metal     <= MetalThrRst;
      thr_q.rise_intf <= RiseIntfThrRst;
      thr_q.fall_intf <= FallIntfThrRst;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

`default_nettype wire

// File: rtl/core/cfsc_div.sv
// ----------------------------------------------------------------------------
// cfsc_div: restoring divider for the calibration average
// Divides the running total by the sample count, one quotient bit a cycle
// through a single narrow subtractor. The quotient is known to fit the count
// width, so the upper total bits seed the partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module cfsc_div #(
  parameter int unsigned CntW = cfsc_pkg::CountWidthDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [CntW+cfsc_pkg::SampW-1:0] dividend_i,
  input  wire  [cfsc_pkg::SampW-1:0]     divisor_i,
  output logic                           done_o,
  output logic [CntW-1:0]                quotient_o
);
  import cfsc_pkg::*;

  localparam int unsigned TotW    = CntW + SampW;
  localparam int unsigned CntBits = $clog2(CntW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  step_q, step_d;
  logic [SampW-1:0]    rem_q, rem_d;
  logic [SampW-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0]     dvd_q, dvd_d;
  logic [SampW:0]      trial;
  logic [SampW:0]      trial_diff;
  logic                trial_ge;

  // Shared trial subtract: shift in the next dividend bit
  assign trial      = {rem_q, dvd_q[CntW-1]};
  assign trial_diff = trial - {1'b0, dvs_q};
  assign trial_ge   = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = dividend_i[TotW-1:CntW];
      dvd_d  = dividend_i[CntW-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // Retire one quotient bit, keep the partial remainder
      rem_d  = trial_ge ? trial_diff[SampW-1:0] : trial[SampW-1:0];
      dvd_d  = {dvd_q[CntW-2:0], trial_ge};
      step_d = step_q + 1'b1;
      if (step_q == CntBits'(CntW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire
